FILE: rtl/srec_pkg.sv
`timescale 1ns / 1ps

package srec_pkg;

   localparam int ADDR_W           = 16;
   localparam int DATA_W           = 8;
   localparam int CHAR_W           = 7;
   localparam int LEN_W            = 5;
   localparam int IDX_W            = 5;
   localparam int CSR_IDX_W        = 2;
   localparam int RECORD_BYTES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ADDR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY      = 2'd2;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [LEN_W-1:0]  HDR_LEN      = 5'd3;
   localparam logic [LEN_W-1:0]  OVERHEAD_LEN = 5'd3;
   localparam logic [CHAR_W-1:0] CH_S         = 7'h53;
   localparam logic [CHAR_W-1:0] CH_NL        = 7'h0A;

   typedef enum logic [1:0] {
      REC_HDR,
      REC_DATA,
      REC_END
   } rec_kind_type;

   typedef struct packed {
      rec_kind_type       kind;
      logic [ADDR_W-1:0]  addr;
      logic [LEN_W-1:0]   len;
      logic               last;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_S,
      BK_TYPE,
      BK_HI,
      BK_LO,
      BK_NL
   } back_state_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] ch;
      if (nib < 4'd10) begin
         ch = 7'h30 + {3'd0, nib};
      end else begin
         ch = 7'h37 + {3'd0, nib};
      end
      return ch;
   endfunction

   function automatic logic [DATA_W-1:0] hdr_byte(input logic [1:0] pos);
      logic [DATA_W-1:0] b;
      unique case (pos)
         2'd0:    b = 8'h48;
         2'd1:    b = 8'h44;
         2'd2:    b = 8'h52;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] type_char(input rec_kind_type kind);
      logic [CHAR_W-1:0] ch;
      unique case (kind)
         REC_HDR:  ch = 7'h30;
         REC_DATA: ch = 7'h31;
         REC_END:  ch = 7'h39;
         default:  ch = 7'h30;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/srec_if.sv
`timescale 1ns / 1ps

interface srec_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface srec_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_of_run;
   logic       image_done;

   modport source (output valid, out_char, last_of_run, image_done, input ready);
   modport sink   (input valid, out_char, last_of_run, image_done, output ready);
endinterface

FILE: rtl/srecord_s19_encoder_unit.sv
`timescale 1ns / 1ps

// S19 text encoder. The req channel carries one item per image byte (kind 0)
// and one end item (kind 1); the rsp channel returns the ASCII characters of
// the records that items cause, with last_of_run on the final character that
// an item causes and image_done on the newline of the closing S9 record.
// The csr port writes start address, end address and entry point; it must be
// used only while the block is idle, which the block itself does not enforce.
// A front stage accepts items, fills the line buffer and queues record
// commands; a back stage turns each command into characters, one per cycle
// while the receiver holds rsp ready high.
// A record of n data bytes is fetched from the queue as one command and sent
// as 2n + 11 characters from the output register. Bytes that do not close a
// line are taken one per cycle while no record command is pending; after the
// byte that closes a line, the next item waits until that line's record has
// been sent. Reset clears the CSR and control registers, the image state and
// the queue; the next item opens a new image with the S0 header. When the
// receiver holds rsp ready low, the output register holds its character and
// the back stage waits; the front keeps taking items until the queue or the
// line buffer is busy.
module srecord_s19_encoder_unit #(
   parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF,
   parameter int QUEUE_DEPTH  = srec_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   srec_req_if.sink                       req,
   srec_rsp_if.source                     rsp,
   input  logic                           csr_wr_en,
   input  logic [srec_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srec_pkg::ADDR_W-1:0]    csr_wdata
);
   import srec_pkg::*;

   localparam int BUF_IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   logic [ADDR_W-1:0]    start_addr_ff;
   logic [ADDR_W-1:0]    end_addr_ff;
   logic [ADDR_W-1:0]    entry_ff;

   logic                 q_push;
   cmd_type              q_push_data;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;
   cmd_type              q_pop_data;
   logic                 s1_done;
   logic [BUF_IDX_W-1:0] buf_rd_addr;
   logic [DATA_W-1:0]    buf_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         end_addr_ff   <= '0;
         entry_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_ADDR: start_addr_ff <= csr_wdata;
            CSR_END_ADDR:   end_addr_ff   <= csr_wdata;
            CSR_ENTRY:      entry_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   srec_front #(
      .RECORD_BYTES (RECORD_BYTES),
      .BUF_IDX_W    (BUF_IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .start_addr  (start_addr_ff),
      .end_addr    (end_addr_ff),
      .entry_addr  (entry_ff),
      .q_push      (q_push),
      .q_data      (q_push_data),
      .q_full      (q_full),
      .s1_done     (s1_done),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data)
   );

   srec_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_pop_data)
   );

   srec_back #(
      .BUF_IDX_W (BUF_IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .s1_done     (s1_done),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data),
      .rsp         (rsp)
   );

endmodule

FILE: rtl/srec_cmd_queue.sv
`timescale 1ns / 1ps

module srec_cmd_queue #(
   parameter int DEPTH = srec_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srec_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output srec_pkg::cmd_type pop_data
);
   import srec_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("command queue count exceeds its depth");

endmodule

FILE: rtl/srec_front.sv
`timescale 1ns / 1ps

module srec_front #(
   parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF,
   parameter int BUF_IDX_W    = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   srec_req_if.sink                       req,
   input  logic [srec_pkg::ADDR_W-1:0]    start_addr,
   input  logic [srec_pkg::ADDR_W-1:0]    end_addr,
   input  logic [srec_pkg::ADDR_W-1:0]    entry_addr,
   output logic                           q_push,
   output srec_pkg::cmd_type              q_data,
   input  logic                           q_full,
   input  logic                           s1_done,
   input  logic [BUF_IDX_W-1:0]           buf_rd_addr,
   output logic [srec_pkg::DATA_W-1:0]    buf_rd_data
);
   import srec_pkg::*;

   logic [DATA_W-1:0] line_buf_ff [RECORD_BYTES];

   logic              hdr_sent_ff, hdr_sent_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] rec_addr_ff, rec_addr_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic              pend_hdr_ff, pend_hdr_in;
   logic              pend_s1_ff, pend_s1_in;
   logic              pend_s9_ff, pend_s9_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [LEN_W-1:0]  s1_len_ff, s1_len_in;
   logic [ADDR_W-1:0] s9_addr_ff, s9_addr_in;
   logic              busy_ff, busy_in;

   logic              accept;
   logic              pend_any;
   logic              buf_we;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] span;
   logic              room;
   logic [LEN_W-1:0]  fill_next;

   assign pend_any    = pend_hdr_ff || pend_s1_ff || pend_s9_ff;
   assign req.ready   = !pend_any && !busy_ff;
   assign accept      = req.valid && req.ready;
   assign buf_rd_data = line_buf_ff[buf_rd_addr];
   assign base_addr   = hdr_sent_ff ? rec_addr_ff : start_addr;
   assign span        = end_addr - start_addr;
   assign room        = (end_addr > start_addr) && (acc_ff < span);
   assign fill_next   = fill_ff + 1'b1;
   assign buf_we      = accept && (req.kind == KIND_DATA) && room;

   always_comb begin
      hdr_sent_in = hdr_sent_ff;
      fill_in     = fill_ff;
      rec_addr_in = rec_addr_ff;
      acc_in      = acc_ff;
      pend_hdr_in = pend_hdr_ff;
      pend_s1_in  = pend_s1_ff;
      pend_s9_in  = pend_s9_ff;
      s1_addr_in  = s1_addr_ff;
      s1_len_in   = s1_len_ff;
      s9_addr_in  = s9_addr_ff;
      busy_in     = busy_ff;
      q_push      = 1'b0;
      q_data      = '{kind: REC_HDR, addr: '0, len: HDR_LEN, last: 1'b0};

      if (s1_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         pend_hdr_in = !hdr_sent_ff;
         hdr_sent_in = 1'b1;
         rec_addr_in = base_addr;
         if (req.kind == KIND_DATA) begin
            if (room) begin
               acc_in = acc_ff + 1'b1;
               if (fill_next == LEN_W'(RECORD_BYTES)) begin
                  pend_s1_in  = 1'b1;
                  s1_addr_in  = base_addr;
                  s1_len_in   = fill_next;
                  rec_addr_in = base_addr + ADDR_W'(RECORD_BYTES);
                  fill_in     = '0;
               end else begin
                  fill_in = fill_next;
               end
            end
         end else begin
            if (fill_ff != '0) begin
               pend_s1_in = 1'b1;
               s1_addr_in = base_addr;
               s1_len_in  = fill_ff;
            end
            pend_s9_in  = 1'b1;
            s9_addr_in  = entry_addr;
            fill_in     = '0;
            rec_addr_in = '0;
            acc_in      = '0;
            hdr_sent_in = 1'b0;
         end
      end else if (pend_any && !q_full) begin
         q_push = 1'b1;
         priority if (pend_hdr_ff) begin
            q_data      = '{kind: REC_HDR, addr: '0, len: HDR_LEN,
                            last: !pend_s1_ff && !pend_s9_ff};
            pend_hdr_in = 1'b0;
         end else if (pend_s1_ff) begin
            q_data     = '{kind: REC_DATA, addr: s1_addr_ff, len: s1_len_ff,
                           last: !pend_s9_ff};
            pend_s1_in = 1'b0;
            busy_in    = 1'b1;
         end else begin
            q_data     = '{kind: REC_END, addr: s9_addr_ff, len: '0, last: 1'b1};
            pend_s9_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_sent_ff <= 1'b0;
         fill_ff     <= '0;
         rec_addr_ff <= '0;
         acc_ff      <= '0;
         pend_hdr_ff <= 1'b0;
         pend_s1_ff  <= 1'b0;
         pend_s9_ff  <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         hdr_sent_ff <= hdr_sent_in;
         fill_ff     <= fill_in;
         rec_addr_ff <= rec_addr_in;
         acc_ff      <= acc_in;
         pend_hdr_ff <= pend_hdr_in;
         pend_s1_ff  <= pend_s1_in;
         pend_s9_ff  <= pend_s9_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= s1_addr_in;
      s1_len_ff  <= s1_len_in;
      s9_addr_ff <= s9_addr_in;
      if (buf_we) begin
         line_buf_ff[fill_ff[BUF_IDX_W-1:0]] <= req.data_byte;
      end
   end

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      s1_done |-> busy_ff)
      else $error("data record finished while no data record was outstanding");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < LEN_W'(RECORD_BYTES))
      else $error("line buffer fill count reached the record size");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      buf_we |-> !busy_ff && !pend_s1_ff)
      else $error("line buffer written while a record still reads it");

endmodule

FILE: rtl/srec_back.sv
`timescale 1ns / 1ps

module srec_back #(
   parameter int BUF_IDX_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  srec_pkg::cmd_type            q_data,
   output logic                         q_pop,
   output logic                         s1_done,
   output logic [BUF_IDX_W-1:0]         buf_rd_addr,
   input  logic [srec_pkg::DATA_W-1:0]  buf_rd_data,
   srec_rsp_if.source                   rsp
);
   import srec_pkg::*;

   back_state_type    state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic              out_vld_ff, out_vld_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic              adv;
   logic              emit;
   logic              is_ck;
   logic [IDX_W-1:0]  data_pos;
   logic [DATA_W-1:0] byte_val;
   logic [CHAR_W-1:0] ch;

   assign adv         = !out_vld_ff || rsp.ready;
   assign is_ck       = (idx_ff == (IDX_W'(cur_ff.len) + IDX_W'(OVERHEAD_LEN)));
   assign data_pos    = idx_ff - IDX_W'(OVERHEAD_LEN);
   assign buf_rd_addr = data_pos[BUF_IDX_W-1:0];

   always_comb begin
      priority if (idx_ff == 5'd0) begin
         byte_val = DATA_W'(cur_ff.len) + DATA_W'(OVERHEAD_LEN);
      end else if (idx_ff == 5'd1) begin
         byte_val = cur_ff.addr[15:8];
      end else if (idx_ff == 5'd2) begin
         byte_val = cur_ff.addr[7:0];
      end else if (is_ck) begin
         byte_val = ~sum_ff;
      end else if (cur_ff.kind == REC_HDR) begin
         byte_val = hdr_byte(data_pos[1:0]);
      end else begin
         byte_val = buf_rd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (q_valid) state_in = BK_S;
         BK_S:    if (adv) state_in = BK_TYPE;
         BK_TYPE: if (adv) state_in = BK_HI;
         BK_HI:   if (adv) state_in = BK_LO;
         BK_LO:   if (adv) state_in = is_ck ? BK_NL : BK_HI;
         BK_NL:   if (adv) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop   = 1'b0;
      emit    = 1'b0;
      s1_done = 1'b0;
      ch      = CH_NL;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cur_in = q_data;
               idx_in = '0;
               sum_in = '0;
            end
         end
         BK_S: begin
            emit = 1'b1;
            ch   = CH_S;
         end
         BK_TYPE: begin
            emit = 1'b1;
            ch   = type_char(cur_ff.kind);
         end
         BK_HI: begin
            emit = 1'b1;
            ch   = hex_char(byte_val[7:4]);
         end
         BK_LO: begin
            emit = 1'b1;
            ch   = hex_char(byte_val[3:0]);
            if (adv && !is_ck) begin
               idx_in = idx_ff + 1'b1;
               sum_in = sum_ff + byte_val;
            end
         end
         BK_NL: begin
            emit    = 1'b1;
            ch      = CH_NL;
            s1_done = adv && (cur_ff.kind == REC_DATA);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      if (adv) begin
         out_vld_in  = emit;
         out_char_in = ch;
         out_last_in = (state_ff == BK_NL) && cur_ff.last;
         out_done_in = (state_ff == BK_NL) && (cur_ff.kind == REC_END);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.out_char    = out_char_ff;
   assign rsp.last_of_run = out_last_ff;
   assign rsp.image_done  = out_done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_done_ff |-> out_last_ff && (out_char_ff == CH_NL))
      else $error("image end flagged on a character that does not close the run");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == BK_S)
      else $error("record command taken without starting a record");

endmodule
